>>> hdl/bdwa_pkg.sv
// Shared types and constants for the base address register decode and window accumulator.
package bdwa_pkg;

   localparam int NUM_CLASS = 5;
   localparam int CLASS_W   = $clog2(NUM_CLASS);

   typedef logic [CLASS_W-1:0] class_idx_type;

   localparam class_idx_type CLS_IO       = CLASS_W'(0);
   localparam class_idx_type CLS_MEM      = CLASS_W'(1);
   localparam class_idx_type CLS_PF_MEM   = CLASS_W'(2);
   localparam class_idx_type CLS_MEM64    = CLASS_W'(3);
   localparam class_idx_type CLS_PF_MEM64 = CLASS_W'(4);

   localparam logic [31:0] ROM_MASK   = 32'hfffff800;
   localparam logic [31:0] IO_MASK    = 32'hfffffffc;
   localparam logic [31:0] MEM_MASK   = 32'hfffffff0;
   localparam logic [31:0] UPPER_ONES = 32'hffffffff;

   localparam logic [1:0] SLOTS_ONE = 2'd1;
   localparam logic [1:0] SLOTS_TWO = 2'd2;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_UNIMPL   = 3'd1,
      ST_BAD_SIZE = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_IO    = 2'd0,
      KIND_MEM32 = 2'd1,
      KIND_MEM64 = 2'd2,
      KIND_ROM   = 2'd3
   } kind_type;

   typedef struct packed {
      logic        start_req;
      logic        rom;
      logic        vf_bar;
      logic [15:0] vf_total;
      logic [31:0] orig_low;
      logic [31:0] orig_high;
      logic [31:0] sized_low;
      logic [31:0] sized_high;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      kind_type    region_kind;
      logic        prefetch;
      logic [63:0] region_base;
      logic [63:0] region_size;
      logic [1:0]  slots_used;
      logic [2:0]  window_class;
      logic [63:0] window_length;
      logic [63:0] window_align;
      kind_type    window_kind;
   } rsp_item_type;

   typedef struct packed {
      logic          start;
      logic          vf;
      logic [15:0]   count;
      logic          unimpl;
      logic          bad_size;
      kind_type      kind;
      logic          prefetch;
      logic          is64;
      class_idx_type cls;
      logic [63:0]   base;
      logic [63:0]   size;
      logic [63:0]   align_mask;
   } dec_type;

   typedef struct packed {
      dec_type     dec;
      logic [63:0] add;
      logic        mul_ovf;
   } scale_type;

   typedef struct packed {
      logic [63:0] length;
      logic [63:0] align;
      kind_type    kind;
   } class_entry_type;

   typedef struct packed {
      logic            en;
      logic            clear;
      class_idx_type   addr;
      class_entry_type data;
   } mem_write_type;

endpackage

>>> hdl/bdwa_if.sv
// Valid/ready channels for request and response items.
interface bdwa_req_if;
   import bdwa_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

interface bdwa_rsp_if;
   import bdwa_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

>>> hdl/bar_decode_window_accumulator.sv
// Base address register decode and window class accumulator, top level.
// Pipeline: decode loads at the item accept, then the scale, class read and output
// registers follow in that order up to response valid.
// Throughput: one item per cycle while the response side is ready; the class total
// read-modify-write keeps up via the class memory read register and write forwarding.
// Reset: clears pipeline valids, class valid bits and the sticky error; classes read as zero.
module bar_decode_window_accumulator (
   input  logic              clock,
   input  logic              reset,
   bdwa_req_if.sink          req_ch,
   bdwa_rsp_if.source        rsp_ch
);
   import bdwa_pkg::*;

   logic            s1_v_ff, s1_v_in;
   logic            s2_v_ff, s2_v_in;
   logic            s3_v_ff, s3_v_in;
   logic            out_v_ff, out_v_in;
   logic            accept;
   logic            s1_adv;
   logic            s2_adv;
   logic            s3_adv;
   dec_type         dec_ff;
   scale_type       sc_ff;
   scale_type       s3_ff;
   class_entry_type rd_entry;
   class_entry_type cur;
   mem_write_type   wr;
   logic            wr_ok;
   logic            err_cur;
   logic            error_ff, error_in;
   logic [64:0]     sum_vf;
   logic [64:0]     sum_al;
   logic [63:0]     rounded;
   logic [63:0]     new_align;
   rsp_item_type    rsp_in;
   rsp_item_type    rsp_ff;

   assign s3_adv       = s3_v_ff && (!out_v_ff || rsp_ch.ready);
   assign s2_adv       = s2_v_ff && (!s3_v_ff || s3_adv);
   assign s1_adv       = s1_v_ff && (!s2_v_ff || s2_adv);
   assign req_ch.ready = !s1_v_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   assign s1_v_in  = accept || (s1_v_ff && !s1_adv);
   assign s2_v_in  = s1_adv || (s2_v_ff && !s2_adv);
   assign s3_v_in  = s2_adv || (s3_v_ff && !s3_adv);
   assign out_v_in = s3_adv || (out_v_ff && !rsp_ch.ready);

   bdwa_decode u_decode (
      .clock  (clock),
      .en     (accept),
      .item   (req_ch.item),
      .dec_ff (dec_ff)
   );

   bdwa_scale u_scale (
      .clock (clock),
      .en    (s1_adv),
      .dec   (dec_ff),
      .sc_ff (sc_ff)
   );

   bdwa_class_mem u_class_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (s2_adv),
      .rd_addr  (sc_ff.dec.cls),
      .wr       (wr),
      .rd_entry (rd_entry)
   );

   always_comb begin
      cur       = s3_ff.dec.start ? '0 : rd_entry;
      err_cur   = !s3_ff.dec.start && error_ff;
      sum_vf    = {1'b0, cur.length} + {1'b0, s3_ff.add};
      sum_al    = {1'b0, cur.length} + {1'b0, s3_ff.dec.align_mask};
      rounded   = sum_al[63:0] | s3_ff.dec.align_mask;
      new_align = (s3_ff.dec.align_mask > cur.align) ? s3_ff.dec.align_mask : cur.align;

      wr_ok    = 1'b0;
      error_in = err_cur;
      wr.data  = cur;

      rsp_in.status        = ST_ADDED;
      rsp_in.region_kind   = s3_ff.dec.kind;
      rsp_in.prefetch      = s3_ff.dec.prefetch;
      rsp_in.region_base   = s3_ff.dec.base;
      rsp_in.region_size   = s3_ff.dec.size;
      rsp_in.slots_used    = s3_ff.dec.is64 ? SLOTS_TWO : SLOTS_ONE;
      rsp_in.window_class  = '0;
      rsp_in.window_length = '0;
      rsp_in.window_align  = '0;
      rsp_in.window_kind   = KIND_IO;

      priority if (err_cur) begin
         rsp_in.status = ST_IGNORED;
      end else if (s3_ff.dec.unimpl) begin
         rsp_in.status = ST_UNIMPL;
      end else if (s3_ff.dec.bad_size) begin
         rsp_in.status = ST_BAD_SIZE;
         error_in      = 1'b1;
      end else begin
         rsp_in.window_class = s3_ff.dec.cls;
         if (s3_ff.dec.vf) begin
            if (s3_ff.mul_ovf || sum_vf[64]) begin
               rsp_in.status = ST_OVERFLOW;
               error_in      = 1'b1;
            end else begin
               wr.data.length = sum_vf[63:0];
               wr_ok          = 1'b1;
            end
         end else begin
            if (sum_al[64] || (&rounded)) begin
               rsp_in.status = ST_OVERFLOW;
               error_in      = 1'b1;
            end else begin
               wr.data.length = rounded + 64'd1;
               wr.data.kind   = s3_ff.dec.kind;
               wr.data.align  = new_align;
               wr_ok          = 1'b1;
            end
         end
         rsp_in.window_length = wr.data.length;
         rsp_in.window_align  = wr.data.align;
         rsp_in.window_kind   = wr.data.kind;
      end

      wr.en    = s3_adv && wr_ok;
      wr.clear = s3_adv && s3_ff.dec.start;
      wr.addr  = s3_ff.dec.cls;
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_ff <= sc_ff;
      end
      if (s3_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         error_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         s3_v_ff  <= s3_v_in;
         out_v_ff <= out_v_in;
         if (s3_adv) begin
            error_ff <= error_in;
         end
      end
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.item  = rsp_ff;

endmodule

>>> hdl/bdwa_decode.sv
// Register readback decode stage: kind, class, base, size and size checks.
module bdwa_decode (
   input  logic                  clock,
   input  logic                  en,
   input  bdwa_pkg::req_item_type item,
   output bdwa_pkg::dec_type      dec_ff
);
   import bdwa_pkg::*;

   logic        io;
   logic        is64;
   logic        pf;
   logic [31:0] low_sel;
   logic [31:0] ml_m;
   logic [63:0] mask64;
   logic [63:0] al;
   logic [63:0] size;
   dec_type     dec_in;

   always_comb begin
      io   = !item.rom && item.orig_low[0];
      is64 = !item.rom && !io && (item.orig_low[2:1] == 2'd2);
      pf   = !item.rom && !io && item.orig_low[3];
      priority if (item.rom) begin
         low_sel = ROM_MASK;
      end else if (io) begin
         low_sel = IO_MASK;
      end else begin
         low_sel = MEM_MASK;
      end
      ml_m   = item.sized_low & low_sel;
      mask64 = is64 ? {item.sized_high, ml_m} : {UPPER_ONES, ml_m};
      al     = ~mask64;
      size   = al + 64'd1;

      dec_in.start      = item.start_req;
      dec_in.vf         = item.vf_bar;
      dec_in.count      = item.vf_total;
      dec_in.unimpl     = (ml_m == '0) && (!is64 || (item.sized_high == '0));
      dec_in.bad_size   = (size == '0) || ((size & al) != '0);
      dec_in.prefetch   = pf;
      dec_in.is64       = is64;
      dec_in.align_mask = al;
      priority if (item.rom) begin
         dec_in.kind = KIND_ROM;
      end else if (io) begin
         dec_in.kind = KIND_IO;
      end else if (is64) begin
         dec_in.kind = KIND_MEM64;
      end else begin
         dec_in.kind = KIND_MEM32;
      end
      priority if (io) begin
         dec_in.cls = CLS_IO;
      end else if (pf) begin
         dec_in.cls = is64 ? CLS_PF_MEM64 : CLS_PF_MEM;
      end else begin
         dec_in.cls = is64 ? CLS_MEM64 : CLS_MEM;
      end
      if (dec_in.unimpl) begin
         dec_in.base = '0;
         dec_in.size = '0;
      end else begin
         dec_in.base = is64 ? {item.orig_high, item.orig_low & low_sel}
                            : {32'h0, item.orig_low & low_sel};
         dec_in.size = size;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff <= dec_in;
      end
   end

endmodule

>>> hdl/bdwa_scale.sv
// Virtual function scaling stage: region size times function count.
module bdwa_scale (
   input  logic                clock,
   input  logic                en,
   input  bdwa_pkg::dec_type   dec,
   output bdwa_pkg::scale_type sc_ff
);
   import bdwa_pkg::*;

   logic [5:0]  expo;
   logic [79:0] prod;
   scale_type   sc_in;

   always_comb begin
      expo = '0;
      for (int i = 0; i < 64; i++) begin
         if (dec.size[i]) begin
            expo = expo | 6'(i);
         end
      end
   end

   assign prod = 80'(dec.count) << expo;

   always_comb begin
      sc_in.dec     = dec;
      sc_in.add     = prod[63:0];
      sc_in.mul_ovf = |prod[79:64];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff <= sc_in;
      end
   end

endmodule

>>> hdl/bdwa_class_mem.sv
// Window class memory with per-entry valid bits and same-cycle write forwarding.
module bdwa_class_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  bdwa_pkg::class_idx_type   rd_addr,
   input  bdwa_pkg::mem_write_type   wr,
   output bdwa_pkg::class_entry_type rd_entry
);
   import bdwa_pkg::*;

   class_entry_type        mem_ff [NUM_CLASS];
   class_entry_type        rd_data_ff;
   class_entry_type        byp_data_ff;
   logic                   rd_valid_ff;
   logic                   byp_ff;
   logic [NUM_CLASS-1:0]   valid_ff;
   logic [NUM_CLASS-1:0]   valid_in;
   logic [NUM_CLASS-1:0]   wr_onehot;

   always_comb begin
      wr_onehot = '0;
      if (wr.en) begin
         wr_onehot[wr.addr] = 1'b1;
      end
      valid_in = (wr.clear ? '0 : valid_ff) | wr_onehot;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         byp_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_in[rd_addr];
            byp_ff      <= wr.en && (wr.addr == rd_addr);
         end
      end
   end

   always_comb begin
      priority if (byp_ff) begin
         rd_entry = byp_data_ff;
      end else if (rd_valid_ff) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry = '0;
      end
   end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the BAR decode and window class accumulator.
module testbench;
   import bdwa_pkg::*;

   localparam int STALL_LIMIT      = 2000;
   localparam int ITEMS_PER_PHASE  = 119;
   localparam int DRAIN_CYCLES     = 8;
   localparam int REPORT_LIMIT     = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdwa_req_if req_ch ();
   bdwa_rsp_if rsp_ch ();

   bar_decode_window_accumulator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [63:0] cls_total_len [NUM_CLASS];
   logic [63:0] cls_max_align [NUM_CLASS];
   kind_type    cls_last_kind [NUM_CLASS];
   logic        sticky_error;

   req_item_type bar_readbacks [$];
   rsp_item_type pending_bar_results [$];
   rsp_item_type exp_rsp;

   int   src_idle_pct;
   int   snk_stall_pct;
   int   idle_cycles;
   int   items_accepted;
   int   results_checked;
   int   mismatch_count;
   int   status_hist [5];
   logic req_taken = 1'b0;
   logic rsp_taken;

   function automatic void clear_windows();
      for (int i = 0; i < NUM_CLASS; i++) begin
         cls_total_len[i] = '0;
         cls_max_align[i] = '0;
         cls_last_kind[i] = KIND_IO;
      end
      sticky_error = 1'b0;
   endfunction

   function automatic rsp_item_type decode_and_accumulate(input req_item_type r);
      rsp_item_type  o;
      logic          io, is64, pf, unimpl, ovf;
      kind_type      kind;
      class_idx_type cls;
      status_type    st;
      logic [63:0]   msk, base, size, len, al;
      logic [64:0]   sum;
      logic [127:0]  prod;
      io   = !r.rom && r.orig_low[0];
      is64 = !r.rom && !io && (r.orig_low[2:1] == 2'd2);
      pf   = !r.rom && !io && r.orig_low[3];
      kind = r.rom ? KIND_ROM : (io ? KIND_IO : (is64 ? KIND_MEM64 : KIND_MEM32));
      cls  = io ? CLS_IO : (pf ? (is64 ? CLS_PF_MEM64 : CLS_PF_MEM)
                               : (is64 ? CLS_MEM64 : CLS_MEM));
      if (r.start_req) begin
         clear_windows();
      end
      if (r.rom) begin
         unimpl = (r.sized_low & ROM_MASK) == '0;
      end else if (io) begin
         unimpl = (r.sized_low & IO_MASK) == '0;
      end else begin
         unimpl = ((r.sized_low & MEM_MASK) == '0) && (!is64 || r.sized_high == '0);
      end
      base = '0;
      size = '0;
      if (!unimpl) begin
         if (r.rom) begin
            msk  = {UPPER_ONES, r.sized_low & ROM_MASK};
            base = {32'd0, r.orig_low & ROM_MASK};
         end else if (io) begin
            msk  = {UPPER_ONES, r.sized_low & IO_MASK};
            base = {32'd0, r.orig_low & IO_MASK};
         end else if (is64) begin
            msk  = {r.sized_high, r.sized_low & MEM_MASK};
            base = {r.orig_high, r.orig_low & MEM_MASK};
         end else begin
            msk  = {UPPER_ONES, r.sized_low & MEM_MASK};
            base = {32'd0, r.orig_low & MEM_MASK};
         end
         size = ~msk + 64'd1;
      end
      o   = '0;
      st  = ST_ADDED;
      ovf = 1'b0;
      if (sticky_error) begin
         st = ST_IGNORED;
      end else if (unimpl) begin
         st = ST_UNIMPL;
      end else if (size == '0 || (size & (size - 64'd1)) != '0) begin
         st = ST_BAD_SIZE;
         sticky_error = 1'b1;
      end else begin
         len = cls_total_len[cls];
         o.window_class = cls;
         if (r.vf_bar) begin
            // scale by the VF count, no alignment
            prod = 128'(size) * 128'(r.vf_total);
            sum  = 65'(len) + 65'(prod[63:0]);
            if (prod[127:64] != '0 || sum[64]) begin
               ovf = 1'b1;
            end else begin
               cls_total_len[cls] = sum[63:0];
            end
         end else begin
            al  = size - 64'd1;
            sum = 65'(len) + 65'(al);
            if (sum[64]) begin
               ovf = 1'b1;
            end else begin
               len = sum[63:0] & ~al;
               sum = 65'(len) + 65'(size);
               if (sum[64]) begin
                  ovf = 1'b1;
               end else begin
                  cls_total_len[cls] = sum[63:0];
                  cls_last_kind[cls] = kind;
                  if (al > cls_max_align[cls]) begin
                     cls_max_align[cls] = al;
                  end
               end
            end
         end
         if (ovf) begin
            st = ST_OVERFLOW;
            sticky_error = 1'b1;
         end
         o.window_length = cls_total_len[cls];
         o.window_align  = cls_max_align[cls];
         o.window_kind   = cls_last_kind[cls];
      end
      o.status      = st;
      o.region_kind = kind;
      o.prefetch    = pf;
      o.region_base = base;
      o.region_size = size;
      o.slots_used  = is64 ? SLOTS_TWO : SLOTS_ONE;
      return o;
   endfunction

   function automatic req_item_type bar_item(input logic st, rm, vf, input logic [15:0] cnt,
                                             input logic [31:0] ol, oh, ml, mh);
      return {st, rm, vf, cnt, ol, oh, ml, mh};
   endfunction

   function automatic req_item_type make_bar_readback();
      req_item_type r;
      logic [63:0]  sz, msk;
      logic [31:0]  addr_mask;
      int unsigned  pick, expo, bitpos;
      logic         big, wide;
      r.start_req  = ($urandom_range(99) < 20);
      r.rom        = 1'b0;
      r.vf_bar     = ($urandom_range(99) < 15);
      r.vf_total   = ($urandom_range(99) < 80) ? 16'($urandom_range(8)) : 16'($urandom);
      r.orig_low   = $urandom;
      r.orig_high  = $urandom;
      r.sized_low  = $urandom;
      r.sized_high = $urandom;
      pick = $urandom_range(99);
      if (pick < 4) begin
         return r;
      end
      big  = ($urandom_range(99) < 8);
      wide = 1'b0;
      case ($urandom_range(3))
         0: begin
            r.orig_low[0] = 1'b1;
            addr_mask = IO_MASK;
            expo = $urandom_range(big ? 31 : 8, 2);
         end
         1: begin
            r.orig_low[0] = 1'b0;
            r.orig_low[2:1] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 2'd3 : 2'd1)
                                                       : 2'd0;
            addr_mask = MEM_MASK;
            expo = $urandom_range(big ? 31 : 20, 4);
         end
         2: begin
            r.orig_low[2:0] = 3'b100;
            addr_mask = MEM_MASK;
            wide = 1'b1;
            expo = $urandom_range(big ? 63 : 24, big ? 40 : 4);
         end
         default: begin
            r.rom = 1'b1;
            addr_mask = ROM_MASK;
            expo = $urandom_range(big ? 31 : 20, 11);
         end
      endcase
      sz  = 64'd1 << expo;
      msk = ~(sz - 64'd1);
      r.sized_low = (msk[31:0] & addr_mask) | (r.orig_low & ~addr_mask);
      if (wide) begin
         r.sized_high = msk[63:32];
      end
      if (pick < 8) begin
         bitpos = $urandom_range(31);
         r.sized_low[bitpos] = ~r.sized_low[bitpos];
      end else if (pick < 12) begin
         r.sized_low  = r.sized_low & ~addr_mask;
         r.sized_high = '0;
      end
      return r;
   endfunction

   function automatic string show_bar_result(input rsp_item_type r);
      return $sformatf("st=%0d k=%0d pf=%0d b=%h s=%h sl=%0d c=%0d l=%h a=%h wk=%0d",
                       r.status, r.region_kind, r.prefetch, r.region_base, r.region_size,
                       r.slots_used, r.window_class, r.window_length, r.window_align,
                       r.window_kind);
   endfunction

   initial begin
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         // advance only once the current item is taken
         if (!req_ch.valid || req_taken) begin
            if (bar_readbacks.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               req_ch.item  <= bar_readbacks.pop_front();
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         req_taken = req_ch.valid && req_ch.ready;
         rsp_taken = rsp_ch.valid && rsp_ch.ready;
         if (req_taken) begin
            pending_bar_results.push_back(decode_and_accumulate(req_ch.item));
            items_accepted++;
         end
         if (rsp_taken) begin
            if (pending_bar_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected result: %s", show_bar_result(rsp_ch.item));
               end
            end else begin
               exp_rsp = pending_bar_results.pop_front();
               results_checked++;
               if (rsp_ch.item.status <= ST_IGNORED) begin
                  status_hist[rsp_ch.item.status]++;
               end
               if (rsp_ch.item.status !== exp_rsp.status ||
                   rsp_ch.item.region_kind !== exp_rsp.region_kind ||
                   rsp_ch.item.prefetch !== exp_rsp.prefetch ||
                   rsp_ch.item.region_base !== exp_rsp.region_base ||
                   rsp_ch.item.region_size !== exp_rsp.region_size ||
                   rsp_ch.item.slots_used !== exp_rsp.slots_used ||
                   rsp_ch.item.window_class !== exp_rsp.window_class ||
                   rsp_ch.item.window_length !== exp_rsp.window_length ||
                   rsp_ch.item.window_align !== exp_rsp.window_align ||
                   rsp_ch.item.window_kind !== exp_rsp.window_kind) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("mismatch on result %0d", results_checked);
                     $display("  expected %s", show_bar_result(exp_rsp));
                     $display("  actual   %s", show_bar_result(rsp_ch.item));
                  end
               end
            end
         end
         if (req_taken || rsp_taken) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int ph;
      req_ch.valid = 1'b0;
      req_ch.item  = '0;
      rsp_ch.ready = 1'b0;
      clear_windows();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // io, mem32, mem64, rom decode with both prefetch settings
      bar_readbacks.push_back(bar_item(1, 0, 0, 0, 32'h0000_1001, 0, 32'hffff_fffd, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff,
                                       32'hffff_ff01, 32'hffff_ffff));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'hfebf_0000, 0, 32'hffff_f000, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'he000_0008, 0, 32'hfff0_0008, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h000c_0002, 0, 32'hffff_0002, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h1000_000e, 0, 32'hffff_f00e, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0001_0004, 32'h0000_0001,
                                       32'hffff_0004, 32'hffff_ffff));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_000c, 32'h0000_0004,
                                       32'h0000_000c, 32'hffff_fffe));
      bar_readbacks.push_back(bar_item(0, 1, 0, 0, 32'hfff0_0001, 0, 32'hffff_0001, 0));
      // virtual function regions, rom with vf, zero count
      bar_readbacks.push_back(bar_item(0, 1, 1, 3, 32'h0000_0000, 0, 32'hffff_f800, 0));
      bar_readbacks.push_back(bar_item(0, 0, 1, 16, 32'h0000_0004, 0,
                                       32'hffff_c004, 32'hffff_ffff));
      bar_readbacks.push_back(bar_item(0, 0, 1, 0, 32'h0000_0000, 0, 32'hfff0_0000, 0));
      // unimplemented registers of each kind
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_0001, 0, 32'h0000_0001, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_0000, 0, 32'h0000_000f, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_0004, 0, 32'h0000_0004, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_0004, 0,
                                       32'h0000_0004, 32'hffff_fff0));
      bar_readbacks.push_back(bar_item(0, 1, 0, 0, 32'h0000_0000, 0, 32'h0000_07ff, 0));
      // invalid size, then items ignored under the sticky error
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_0000, 0, 32'hfff0_f000, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_2001, 0, 32'hffff_ff01, 0));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_0000, 0, 32'h0000_0000, 0));
      // largest region twice overflows the class, then the vf product overflow
      bar_readbacks.push_back(bar_item(1, 0, 0, 0, 32'h0000_000c, 0,
                                       32'h0000_000c, 32'h8000_0000));
      bar_readbacks.push_back(bar_item(0, 0, 0, 0, 32'h0000_000c, 0,
                                       32'h0000_000c, 32'h8000_0000));
      bar_readbacks.push_back(bar_item(1, 0, 1, 16'hffff, 32'h0000_000c, 0,
                                       32'h0000_000c, 32'h8000_0000));
      bar_readbacks.push_back(bar_item(1, 1, 1, 16'hffff, 32'hffff_ffff, 32'hffff_ffff,
                                       32'hffff_ffff, 32'hffff_ffff));
      bar_readbacks.push_back(bar_item(1, 0, 0, 0, 0, 0, 0, 0));

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               src_idle_pct  = 0;
               snk_stall_pct = 0;
            end
            1: begin
               src_idle_pct  = 67;
               snk_stall_pct = 0;
            end
            2: begin
               src_idle_pct  = 0;
               snk_stall_pct = 67;
            end
            default: begin
               src_idle_pct  = 15;
               snk_stall_pct = 15;
            end
         endcase
         repeat (ITEMS_PER_PHASE) bar_readbacks.push_back(make_bar_readback());
         while (bar_readbacks.size() != 0) @(posedge clock);
      end

      while (req_ch.valid || pending_bar_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d BAR readbacks through four pacing phases, %0d results checked",
               items_accepted, results_checked);
      $display("Statuses: %0d added, %0d unimplemented, %0d bad size, %0d overflow, %0d ignored",
               status_hist[ST_ADDED], status_hist[ST_UNIMPL], status_hist[ST_BAD_SIZE],
               status_hist[ST_OVERFLOW], status_hist[ST_IGNORED]);
      if (mismatch_count == 0 && pending_bar_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
